FILE: hw/rtl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types, codes and palette helpers for the curvature colour mapper.
// ----------------------------------------------------------------------------
package ccm_pkg;

  // field widths
  localparam int unsigned CURV_W  = 24;
  localparam int unsigned BARY_W  = 17;
  localparam int unsigned RANGE_W = 23;
  localparam int unsigned CHAN_W  = 13;
  localparam int unsigned FRAC_W  = 12;

  // register indexes
  localparam logic [1:0] CFG_CLAMP_MODE = 2'd0;
  localparam logic [1:0] CFG_COLOR_MODE = 2'd1;
  localparam logic [1:0] CFG_RANGE_MIN  = 2'd2;
  localparam logic [1:0] CFG_RANGE_MAX  = 2'd3;

  // clamp modes, the unused code behaves as no clamp
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_POS  = 2'd1;
  localparam logic [1:0] CLAMP_NEG  = 2'd2;

  // palettes, the unused code behaves as the gray ramp
  localparam logic [1:0] PAL_GRAY  = 2'd0;
  localparam logic [1:0] PAL_RGB   = 2'd1;
  localparam logic [1:0] PAL_RKB   = 2'd2;

  // register reset values
  localparam logic [RANGE_W-1:0] RANGE_MIN_RST = 23'd0;
  localparam logic [RANGE_W-1:0] RANGE_MAX_RST = 23'd65536;

  // Q0.12 one
  localparam logic [CHAN_W-1:0] T_ONE = 13'd4096;

  typedef struct packed {
    logic                     has_sample;
    logic                     tri_valid;
    logic signed [CURV_W-1:0] curv_a;
    logic signed [CURV_W-1:0] curv_b;
    logic signed [CURV_W-1:0] curv_c;
    logic        [BARY_W-1:0] bary_a;
    logic        [BARY_W-1:0] bary_b;
    logic        [BARY_W-1:0] bary_c;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } out_item_t;

  // control travelling with each pipeline slot
  typedef struct packed {
    logic valid;
    logic blank;
    logic neg;
  } pipe_ctl_t;

  // palette entry selectors
  typedef enum logic [1:0] {
    ENT_NEG,
    ENT_ZERO,
    ENT_POS
  } pal_ent_t;

  // palette level of one channel
  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_HALF,
    LVL_FULL
  } level_t;

  // level of channel ch (0 red, 1 green, 2 blue) for a palette entry
  function automatic level_t pal_level(logic [1:0] mode, pal_ent_t ent, logic [1:0] ch);
    level_t lv;
    lv = LVL_NONE;
    unique case (mode)
      PAL_RGB: begin
        unique case (ent)
          ENT_NEG:  lv = (ch == 2'd0) ? LVL_FULL : LVL_NONE;
          ENT_ZERO: lv = (ch == 2'd1) ? LVL_FULL : LVL_NONE;
          default:  lv = (ch == 2'd2) ? LVL_FULL : LVL_NONE;
        endcase
      end
      PAL_RKB: begin
        unique case (ent)
          ENT_NEG:  lv = (ch == 2'd0) ? LVL_FULL : LVL_NONE;
          ENT_ZERO: lv = LVL_NONE;
          default:  lv = (ch == 2'd2) ? LVL_FULL : LVL_NONE;
        endcase
      end
      default: begin
        unique case (ent)
          ENT_NEG:  lv = LVL_NONE;
          ENT_ZERO: lv = LVL_HALF;
          default:  lv = LVL_FULL;
        endcase
      end
    endcase
    return lv;
  endfunction

  // level times a Q0.12 weight, as shifts
  function automatic logic [25:0] level_scale(level_t lv, logic [CHAN_W-1:0] x);
    logic [25:0] p;
    unique case (lv)
      LVL_HALF: p = {2'b00, x, 11'd0};
      LVL_FULL: p = {1'b0, x, 12'd0};
      default:  p = 26'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/ccm_mix.sv
// ----------------------------------------------------------------------------
// ccm_mix
// Clamp and weight the three curvatures, round, saturate and take magnitude.
// Two register stages: products, then magnitude and sign.
// ----------------------------------------------------------------------------
module ccm_mix (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  ccm_pkg::in_item_t         in_item,
  input  logic [1:0]                clamp_mode,
  output ccm_pkg::pipe_ctl_t        mix_ctl,
  output logic [ccm_pkg::CURV_W-1:0] mix_mag
);
  import ccm_pkg::*;

  localparam int unsigned PROD_W = CURV_W + BARY_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned SH_W   = SUM_W - 16;

  logic signed [CURV_W-1:0] curv   [3];
  logic        [BARY_W-1:0] bary   [3];
  logic signed [CURV_W-1:0] c_lim  [3];
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic                     s1_valid_r;
  logic                     s1_blank_r;
  logic                     s1_tri_r;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh;
  logic signed [CURV_W-1:0] mix;
  logic signed [CURV_W:0]   mix_abs;
  pipe_ctl_t                ctl_r;
  logic [CURV_W-1:0]        mag_r;

  assign curv[0] = in_item.curv_a;
  assign curv[1] = in_item.curv_b;
  assign curv[2] = in_item.curv_c;
  assign bary[0] = in_item.bary_a;
  assign bary[1] = in_item.bary_b;
  assign bary[2] = in_item.bary_c;

  // clamp by mode and weight each vertex
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_lim[k] = curv[k];
      if (clamp_mode == CLAMP_POS && curv[k] < 0) c_lim[k] = '0;
      if (clamp_mode == CLAMP_NEG && curv[k] > 0) c_lim[k] = '0;
      prod_nxt[k] = c_lim[k] * $signed({1'b0, bary[k]});
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_blank_r <= ~in_item.has_sample;
    s1_tri_r   <= in_item.tri_valid;
    for (int k = 0; k < 3; k++) prod_r[k] <= prod_nxt[k];
  end

  // sum, round half up, saturate, magnitude
  always_comb begin
    sum = $signed({{2{prod_r[0][PROD_W-1]}}, prod_r[0]})
        + $signed({{2{prod_r[1][PROD_W-1]}}, prod_r[1]})
        + $signed({{2{prod_r[2][PROD_W-1]}}, prod_r[2]})
        + $signed(SUM_W'(32768));
    sh = sum[SUM_W-1:16];
    if (sh > $signed(SH_W'(8388607))) begin
      mix = 24'sh7FFFFF;
    end else if (sh < -$signed(SH_W'(8388608))) begin
      mix = 24'sh800000;
    end else begin
      mix = sh[CURV_W-1:0];
    end
    if (!s1_tri_r) mix = '0;
    mix_abs = mix[CURV_W-1] ? -$signed({mix[CURV_W-1], mix}) : $signed({mix[CURV_W-1], mix});
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= s1_valid_r;
    end
    ctl_r.blank <= s1_blank_r;
    ctl_r.neg   <= mix[CURV_W-1];
    mag_r       <= mix_abs[CURV_W-1:0];
  end

  assign mix_ctl = ctl_r;
  assign mix_mag = mag_r;

endmodule

FILE: hw/rtl/ccm_norm.sv
// ----------------------------------------------------------------------------
// ccm_norm
// Normalise the magnitude into the configured range as a Q0.12 fraction.
// One classify stage, then a restoring divider with one quotient bit a stage.
// ----------------------------------------------------------------------------
module ccm_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccm_pkg::pipe_ctl_t          mix_ctl,
  input  logic [ccm_pkg::CURV_W-1:0]  mix_mag,
  input  logic [ccm_pkg::RANGE_W-1:0] range_min,
  input  logic [ccm_pkg::RANGE_W-1:0] range_max,
  output ccm_pkg::pipe_ctl_t          norm_ctl,
  output logic [ccm_pkg::CHAN_W-1:0]  norm_t
);
  import ccm_pkg::*;

  typedef enum logic [1:0] {
    T_ZERO,
    T_FULL,
    T_DIV
  } t_kind_t;

  pipe_ctl_t          ctl_r  [FRAC_W+1];
  t_kind_t            kind_r [FRAC_W+1];
  logic [RANGE_W-1:0] rem_r  [FRAC_W+1];
  logic [RANGE_W-1:0] dv_r   [FRAC_W+1];
  logic [FRAC_W-1:0]  q_r    [FRAC_W+1];

  t_kind_t            kind_nxt;
  logic [CURV_W-1:0]  d_full;
  logic [CURV_W-1:0]  dv_full;

  // classify against the range bounds
  always_comb begin
    d_full  = mix_mag - {1'b0, range_min};
    dv_full = {1'b0, range_max} - {1'b0, range_min};
    priority if (mix_mag <= {1'b0, range_min}) begin
      kind_nxt = T_ZERO;
    end else if (mix_mag >= {1'b0, range_max}) begin
      kind_nxt = T_FULL;
    end else begin
      kind_nxt = T_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else begin
      ctl_r[0].valid <= mix_ctl.valid;
    end
    ctl_r[0].blank <= mix_ctl.blank;
    ctl_r[0].neg   <= mix_ctl.neg;
    kind_r[0]      <= kind_nxt;
    rem_r[0]       <= d_full[RANGE_W-1:0];
    dv_r[0]        <= dv_full[RANGE_W-1:0];
    q_r[0]         <= '0;
  end

  // divider stages, remainder stays below the divisor
  for (genvar i = 1; i <= FRAC_W; i++) begin : g_div
    logic [RANGE_W:0]   rem2;
    logic               ge;
    logic [RANGE_W:0]   diff;
    logic [RANGE_W-1:0] rem_nxt;

    always_comb begin
      rem2    = {rem_r[i-1], 1'b0};
      diff    = rem2 - {1'b0, dv_r[i-1]};
      ge      = rem2 >= {1'b0, dv_r[i-1]};
      rem_nxt = ge ? diff[RANGE_W-1:0] : rem2[RANGE_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i].valid <= 1'b0;
      end else begin
        ctl_r[i].valid <= ctl_r[i-1].valid;
      end
      ctl_r[i].blank <= ctl_r[i-1].blank;
      ctl_r[i].neg   <= ctl_r[i-1].neg;
      kind_r[i]      <= kind_r[i-1];
      rem_r[i]       <= rem_nxt;
      dv_r[i]        <= dv_r[i-1];
      q_r[i]         <= {q_r[i-1][FRAC_W-2:0], ge};
    end
  end

  // pick the fraction at the end of the divider
  always_comb begin
    unique case (kind_r[FRAC_W])
      T_ZERO:  norm_t = '0;
      T_FULL:  norm_t = T_ONE;
      default: norm_t = {1'b0, q_r[FRAC_W]};
    endcase
  end

  assign norm_ctl = ctl_r[FRAC_W];

endmodule

FILE: hw/rtl/ccm_shade.sv
// ----------------------------------------------------------------------------
// ccm_shade
// Blend the zero colour toward the negative or positive palette colour and
// register the result strobe.
// ----------------------------------------------------------------------------
module ccm_shade (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ccm_pkg::pipe_ctl_t         norm_ctl,
  input  logic [ccm_pkg::CHAN_W-1:0] norm_t,
  input  logic [1:0]                 color_mode,
  output logic                       out_valid,
  output ccm_pkg::out_item_t         out_data
);
  import ccm_pkg::*;

  logic [CHAN_W-1:0] t_inv;
  logic [CHAN_W-1:0] chan [3];
  logic [25:0]       acc  [3];
  pal_ent_t          tgt;
  logic              valid_r;
  out_item_t         data_r;

  // channel = (zero*(1-t) + target*t + half) >> 12
  always_comb begin
    t_inv = T_ONE - norm_t;
    tgt   = norm_ctl.neg ? ENT_NEG : ENT_POS;
    for (int k = 0; k < 3; k++) begin
      acc[k] = level_scale(pal_level(color_mode, ENT_ZERO, 2'(k)), t_inv)
             + level_scale(pal_level(color_mode, tgt, 2'(k)), norm_t)
             + 26'd2048;
      chan[k] = norm_ctl.blank ? '0 : acc[k][FRAC_W +: CHAN_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= norm_ctl.valid;
    end
    data_r.red   <= chan[0];
    data_r.green <= chan[1];
    data_r.blue  <= chan[2];
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/curvature_color_mapper.sv
// Throughput: one sample per cycle; busy stays low and start is never held off.
// Stages: two for the weighted mix, one range classify, twelve divider steps, one output.
// Reset (synchronous, rst_n low) clears all pipeline valid bits and loads
// the register reset values; the receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
// curvature_color_mapper
// Maps interpolated mesh curvature of a texel sample to an RGB palette colour.
// ----------------------------------------------------------------------------
module curvature_color_mapper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ccm_pkg::in_item_t           in_data,
  output logic                        out_valid,
  output ccm_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [ccm_pkg::RANGE_W-1:0] cfg_data
);
  import ccm_pkg::*;

  logic [1:0]         clamp_mode_r;
  logic [1:0]         color_mode_r;
  logic [RANGE_W-1:0] range_min_r;
  logic [RANGE_W-1:0] range_max_r;
  pipe_ctl_t          mix_ctl;
  logic [CURV_W-1:0]  mix_mag;
  pipe_ctl_t          norm_ctl;
  logic [CHAN_W-1:0]  norm_t;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_mode_r <= CLAMP_NONE;
      color_mode_r <= PAL_GRAY;
      range_min_r  <= RANGE_MIN_RST;
      range_max_r  <= RANGE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLAMP_MODE: clamp_mode_r <= cfg_data[1:0];
        CFG_COLOR_MODE: color_mode_r <= cfg_data[1:0];
        CFG_RANGE_MIN:  range_min_r  <= cfg_data;
        CFG_RANGE_MAX:  range_max_r  <= cfg_data;
      endcase
    end
  end

  // weighted mix
  ccm_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .in_item    (in_data),
    .clamp_mode (clamp_mode_r),
    .mix_ctl    (mix_ctl),
    .mix_mag    (mix_mag)
  );

  // range normalisation
  ccm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_ctl   (mix_ctl),
    .mix_mag   (mix_mag),
    .range_min (range_min_r),
    .range_max (range_max_r),
    .norm_ctl  (norm_ctl),
    .norm_t    (norm_t)
  );

  // palette blend and output
  ccm_shade u_shade (
    .clk        (clk),
    .rst_n      (rst_n),
    .norm_ctl   (norm_ctl),
    .norm_t     (norm_t),
    .color_mode (color_mode_r),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

FILE: hw/rtl/ccm_checker.sv
// ----------------------------------------------------------------------------
// ccm_checker
// Port-level checks of the curvature colour mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ccm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input ccm_pkg::in_item_t           in_data,
  input logic                        out_valid,
  input ccm_pkg::out_item_t          out_data
);
  import ccm_pkg::*;

  localparam int unsigned LAT = 16;

  // every accepted sample gives one strobe after the pipeline latency
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("missing result strobe");

  // no strobe without a transfer in at the matching edge
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a sample");

  // a missing sample comes out black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.has_sample) |-> ##LAT
      (out_data.red == '0 && out_data.green == '0 && out_data.blue == '0))
    else $error("missing sample not black");

  // channels never exceed one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red <= T_ONE && out_data.green <= T_ONE &&
                   out_data.blue <= T_ONE))
    else $error("channel above one");

endmodule

bind curvature_color_mapper ccm_checker u_ccm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: tb/sv/curvature_color_mapper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curvature_color_mapper_test
// Streams texel samples through the curvature colour mapper under a series of
// clamp, palette and range settings. Every accepted sample is turned into an
// expected colour by a local predictor, and each result strobe is compared
// channel by channel with the oldest outstanding colour.
// ----------------------------------------------------------------------------
module curvature_color_mapper_test;
  import ccm_pkg::*;

  localparam int  LATENCY        = 16;
  localparam int  NUM_PHASES     = 9;
  localparam int  RAND_PER_PHASE = 160;
  localparam int  CURV_HI        = 8388607;
  localparam int  CURV_LO        = -8388608;
  localparam int  BARY_ONE       = 65536;
  localparam int  BARY_MAX       = 131071;
  localparam logic [RANGE_W-1:0] RANGE_TOP = 23'd8388607;
  localparam time LIMIT_NS       = 5_000_000;

  // codes left unused by the package, decoded as the defaults
  localparam logic [1:0] CLAMP_SPARE = 2'd3;
  localparam logic [1:0] PAL_SPARE   = 2'd3;

  localparam logic [CHAN_W-1:0] LVL_ZERO_C = 13'd0;
  localparam logic [CHAN_W-1:0] LVL_HALF_C = 13'd2048;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = CFG_CLAMP_MODE;
  logic [RANGE_W-1:0]   cfg_data  = '0;

  // local copy of the register file
  logic [1:0]           clamp_sel   = CLAMP_NONE;
  logic [1:0]           palette_sel = PAL_GRAY;
  logic [RANGE_W-1:0]   lo_bound    = RANGE_MIN_RST;
  logic [RANGE_W-1:0]   hi_bound    = RANGE_MAX_RST;

  in_item_t             pending_samples[$];
  out_item_t            colour_q[$];
  int                   samples_owed = 0;
  int                   mismatches   = 0;
  int                   burst_left   = 1;
  int                   gap_left     = 0;
  logic                 steady       = 1'b0;

  curvature_color_mapper uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected colour of one sample under the current register copy
  function automatic out_item_t predict_colour(in_item_t s);
    longint acc, cv, wt, mixv, mag, t, lo, hi, lvl;
    logic [2:0][CHAN_W-1:0] zero_lv, neg_lv, pos_lv, tgt_lv, rgb;
    out_item_t r;
    acc  = 0;
    mixv = 0;
    if (!s.has_sample) return '0;
    // weighted mix of the clamped vertex curvatures
    if (s.tri_valid) begin
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: begin
            cv = $signed(s.curv_a);
            wt = s.bary_a;
          end
          1: begin
            cv = $signed(s.curv_b);
            wt = s.bary_b;
          end
          default: begin
            cv = $signed(s.curv_c);
            wt = s.bary_c;
          end
        endcase
        if (clamp_sel == CLAMP_POS && cv < 0) cv = 0;
        else if (clamp_sel == CLAMP_NEG && cv > 0) cv = 0;
        acc += cv * wt;
      end
      // round half up back to Q8.16, then saturate
      mixv = (acc + 32768) >>> 16;
      if (mixv > CURV_HI) mixv = CURV_HI;
      else if (mixv < CURV_LO) mixv = CURV_LO;
    end
    // normalised magnitude in Q0.12
    mag = (mixv < 0) ? -mixv : mixv;
    lo  = lo_bound;
    hi  = hi_bound;
    if (mag <= lo) t = 0;
    else if (mag >= hi) t = T_ONE;
    else t = ((mag - lo) * T_ONE) / (hi - lo);
    // palette entries, packed as blue, green, red
    case (palette_sel)
      PAL_RGB: begin
        neg_lv  = {LVL_ZERO_C, LVL_ZERO_C, T_ONE};
        zero_lv = {LVL_ZERO_C, T_ONE, LVL_ZERO_C};
        pos_lv  = {T_ONE, LVL_ZERO_C, LVL_ZERO_C};
      end
      PAL_RKB: begin
        neg_lv  = {LVL_ZERO_C, LVL_ZERO_C, T_ONE};
        zero_lv = {LVL_ZERO_C, LVL_ZERO_C, LVL_ZERO_C};
        pos_lv  = {T_ONE, LVL_ZERO_C, LVL_ZERO_C};
      end
      default: begin
        neg_lv  = {LVL_ZERO_C, LVL_ZERO_C, LVL_ZERO_C};
        zero_lv = {LVL_HALF_C, LVL_HALF_C, LVL_HALF_C};
        pos_lv  = {T_ONE, T_ONE, T_ONE};
      end
    endcase
    tgt_lv = (mixv < 0) ? neg_lv : pos_lv;
    // blend from the zero colour toward the target
    for (int k = 0; k < 3; k++) begin
      lvl = (longint'(zero_lv[k]) * (T_ONE - t) + longint'(tgt_lv[k]) * t + 2048) >> 12;
      rgb[k] = lvl[CHAN_W-1:0];
    end
    r.red   = rgb[0];
    r.green = rgb[1];
    r.blue  = rgb[2];
    return r;
  endfunction

  function automatic in_item_t make_item(input logic has, input logic tri_ok,
                                         input int ca, input int cb, input int cc,
                                         input int wa, input int wb, input int wc);
    in_item_t s;
    s.has_sample = has;
    s.tri_valid  = tri_ok;
    s.curv_a     = ca[CURV_W-1:0];
    s.curv_b     = cb[CURV_W-1:0];
    s.curv_c     = cc[CURV_W-1:0];
    s.bary_a     = wa[BARY_W-1:0];
    s.bary_b     = wb[BARY_W-1:0];
    s.bary_c     = wc[BARY_W-1:0];
    return s;
  endfunction

  // random sample, mostly weights summing to one and curvatures near the range
  function automatic in_item_t random_sample();
    int cv[3];
    int wv[3];
    int span, base, pick, shape, wshape, mag, a, b, rot;
    span = (lo_bound > hi_bound) ? int'(lo_bound) : int'(hi_bound);
    span = span + span / 2 + 64;
    if (span > CURV_HI) span = CURV_HI;
    shape = $urandom_range(0, 9);
    base  = $urandom_range(0, span);
    if ($urandom_range(0, 1) != 0) base = -base;
    for (int k = 0; k < 3; k++) begin
      if (shape <= 1) begin
        cv[k] = $urandom_range(0, 16777215) - 8388608;
      end else if (shape == 2) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: cv[k] = CURV_HI;
          1: cv[k] = CURV_LO;
          2: cv[k] = 0;
          3: cv[k] = -1;
          default: cv[k] = 1;
        endcase
      end else if (shape <= 5) begin
        mag   = $urandom_range(0, span);
        cv[k] = ($urandom_range(0, 1) != 0) ? -mag : mag;
      end else begin
        // vertices close to a common value so the mix lands inside the range
        cv[k] = base + $urandom_range(0, 2048) - 1024;
        if (cv[k] > CURV_HI) cv[k] = CURV_HI;
        else if (cv[k] < CURV_LO) cv[k] = CURV_LO;
      end
    end
    wshape = $urandom_range(0, 9);
    if (wshape < 8) begin
      a   = $urandom_range(0, BARY_ONE);
      b   = $urandom_range(0, BARY_ONE - a);
      rot = $urandom_range(0, 2);
      wv[rot]           = a;
      wv[(rot + 1) % 3] = b;
      wv[(rot + 2) % 3] = BARY_ONE - a - b;
    end else if (wshape == 8) begin
      for (int k = 0; k < 3; k++) wv[k] = $urandom_range(0, BARY_MAX);
    end else begin
      for (int k = 0; k < 3; k++) begin
        pick  = $urandom_range(0, 2);
        wv[k] = (pick == 0) ? 0 : ((pick == 1) ? BARY_ONE : BARY_MAX);
      end
    end
    return make_item($urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                     cv[0], cv[1], cv[2], wv[0], wv[1], wv[2]);
  endfunction

  // one register transfer, mirrored into the local copy on acceptance
  task automatic cfg_write(input logic [1:0] idx, input logic [RANGE_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLAMP_MODE: clamp_sel   = val[1:0];
      CFG_COLOR_MODE: palette_sel = val[1:0];
      CFG_RANGE_MIN:  lo_bound    = val;
      default:        hi_bound    = val;
    endcase
  endtask

  task automatic queue_sample(input in_item_t s);
    pending_samples.push_back(s);
    samples_owed++;
  endtask

  // sample driver: bursts of transfers with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) colour_q.push_back(predict_colour(in_data));
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_data <= pending_samples.pop_front();
        start   <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          if (steady) gap_left = 0;
          else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(4, 20);
          else gap_left = $urandom_range(0, 2);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (colour_q.size() == 0) begin
        $display("%0t: colour with none outstanding, expected none, actual %h",
                 $time, out_data);
        mismatches++;
      end else begin
        want = colour_q.pop_front();
        if (out_data.red !== want.red) begin
          $display("%0t: red mismatch, expected %0d, actual %0d",
                   $time, want.red, out_data.red);
          mismatches++;
        end
        if (out_data.green !== want.green) begin
          $display("%0t: green mismatch, expected %0d, actual %0d",
                   $time, want.green, out_data.green);
          mismatches++;
        end
        if (out_data.blue !== want.blue) begin
          $display("%0t: blue mismatch, expected %0d, actual %0d",
                   $time, want.blue, out_data.blue);
          mismatches++;
        end
        samples_owed--;
      end
    end
  end

  // phases of register settings and sample streams
  initial begin
    logic [1:0]         c_clamp, c_pal;
    logic [RANGE_W-1:0] c_lo, c_hi;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: begin c_clamp = CLAMP_POS;  c_pal = PAL_RGB;  c_lo = 0;       c_hi = 262144;    end
          2: begin c_clamp = CLAMP_NEG;  c_pal = PAL_RKB;  c_lo = 1000;    c_hi = 300000;    end
          3: begin c_clamp = CLAMP_SPARE; c_pal = PAL_SPARE; c_lo = 0;     c_hi = RANGE_TOP; end
          4: begin c_clamp = CLAMP_NONE; c_pal = PAL_RKB;  c_lo = RANGE_TOP; c_hi = RANGE_TOP; end
          5: begin c_clamp = CLAMP_NONE; c_pal = PAL_GRAY; c_lo = 500000;  c_hi = 100;       end
          6: begin
            c_clamp = 2'($urandom_range(0, 3));
            c_pal   = 2'($urandom_range(0, 3));
            c_lo    = RANGE_W'($urandom_range(0, 1 << 20));
            c_hi    = RANGE_W'($urandom_range(0, 1 << 20));
          end
          7: begin c_clamp = CLAMP_NONE; c_pal = PAL_RGB;  c_lo = 0;       c_hi = 0;         end
          default: begin
            c_clamp = CLAMP_NEG; c_pal = PAL_GRAY; c_lo = 65536; c_hi = 65537;
          end
        endcase
        cfg_write(CFG_CLAMP_MODE, {21'd0, c_clamp});
        cfg_write(CFG_COLOR_MODE, {21'd0, c_pal});
        cfg_write(CFG_RANGE_MIN, c_lo);
        cfg_write(CFG_RANGE_MAX, c_hi);
      end else begin
        // directed samples under the reset settings
        queue_sample(make_item(1'b0, 1'b1, CURV_HI, CURV_LO, -1, BARY_MAX, BARY_ONE, 0));
        queue_sample(make_item(1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        queue_sample(make_item(1'b1, 1'b0, CURV_HI, CURV_HI, CURV_HI, BARY_ONE, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, 0, 0, 0, BARY_ONE, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, CURV_HI, CURV_HI, CURV_HI, BARY_ONE, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, CURV_LO, CURV_LO, CURV_LO, 0, 0, BARY_ONE));
        queue_sample(make_item(1'b1, 1'b1, CURV_HI, CURV_HI, CURV_HI,
                               BARY_MAX, BARY_MAX, BARY_MAX));
        queue_sample(make_item(1'b1, 1'b1, CURV_LO, CURV_LO, CURV_LO,
                               BARY_MAX, BARY_MAX, BARY_MAX));
        // rounding ties on either side of zero
        queue_sample(make_item(1'b1, 1'b1, 1, 0, 0, 32768, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, -1, 0, 0, 32768, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, 0, -3, 0, 0, 32768, 0));
        // inside and at the edges of the range
        queue_sample(make_item(1'b1, 1'b1, 32768, 32768, 32768, 0, BARY_ONE, 0));
        queue_sample(make_item(1'b1, 1'b1, -32768, 0, 0, BARY_ONE, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, 65536, 0, 0, BARY_ONE, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, 0, 0, -65535, 0, 0, BARY_ONE));
        queue_sample(make_item(1'b1, 1'b1, CURV_HI, CURV_LO, -77, 0, 0, 0));
        queue_sample(make_item(1'b1, 1'b1, CURV_HI, CURV_LO, 12345, 21845, 21845, 21846));
        queue_sample(make_item(1'b1, 1'b1, -1, -1, -1, BARY_MAX, BARY_MAX, BARY_MAX));
      end
      steady = (ph % 3 == 2);
      repeat (RAND_PER_PHASE) queue_sample(random_sample());
      // idle before the next register transfers
      while (samples_owed != 0) @(posedge clk);
    end
    repeat (LATENCY + 8) @(posedge clk);
    if (colour_q.size() != 0) begin
      $display("%0t: colours left over, expected 0, actual %0d", $time, colour_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
